FILE: design/dwhs_pkg.sv
package dwhs_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SLEEP_FORCE   = 3'd0;
    localparam logic [2:0] REG_READY_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_ACK_PULSE     = 3'd2;
    localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_SLEEP_PRESENT = 3'd4;
    localparam logic [2:0] REG_FAULT_PRESENT = 3'd5;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;
    localparam int TickWidth     = 16;

    // Reset values of the configuration registers
    localparam logic [TickWidth-1:0] SLEEP_FORCE_RST   = 16'd2000;
    localparam logic [TickWidth-1:0] READY_TIMEOUT_RST = 16'd5000;
    localparam logic [TickWidth-1:0] ACK_PULSE_RST     = 16'd22;
    localparam logic [TickWidth-1:0] ACK_TIMEOUT_RST   = 16'd5000;

    // Handshake outcome codes
    localparam logic [1:0] OUT_NOTRUN = 2'd0;
    localparam logic [1:0] OUT_OK     = 2'd1;
    localparam logic [1:0] OUT_FAIL   = 2'd2;
    localparam logic [1:0] OUT_UNVER  = 2'd3;

    typedef struct packed {
        logic [TickWidth-1:0] sleep_force_ticks;
        logic [TickWidth-1:0] ready_timeout_ticks;
        logic [TickWidth-1:0] ack_pulse_ticks;
        logic [TickWidth-1:0] ack_timeout_ticks;
        logic                 sleep_pin_present;
        logic                 fault_pin_present;
    } cfg_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic       done_res;
        logic       busy_res;
        logic       sleep_level;
    } result_t;

    localparam int ResultWidth = $bits(result_t);

endpackage

FILE: design/dwhs_cfg.sv
module dwhs_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [dwhs_pkg::CfgIndexWidth-1:0]   wr_index,
    input  logic [dwhs_pkg::CfgDataWidth-1:0]    wr_data,
    output dwhs_pkg::cfg_t                       cfg
);
    import dwhs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_force_ticks   <= SLEEP_FORCE_RST;
            cfg_reg.ready_timeout_ticks <= READY_TIMEOUT_RST;
            cfg_reg.ack_pulse_ticks     <= ACK_PULSE_RST;
            cfg_reg.ack_timeout_ticks   <= ACK_TIMEOUT_RST;
            cfg_reg.sleep_pin_present   <= 1'b1;
            cfg_reg.fault_pin_present   <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SLEEP_FORCE:   cfg_reg.sleep_force_ticks   <= wr_data;
                REG_READY_TIMEOUT: cfg_reg.ready_timeout_ticks <= wr_data;
                REG_ACK_PULSE:     cfg_reg.ack_pulse_ticks     <= wr_data;
                REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ticks   <= wr_data;
                REG_SLEEP_PRESENT: cfg_reg.sleep_pin_present   <= wr_data[0];
                REG_FAULT_PRESENT: cfg_reg.fault_pin_present   <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/dwhs_core.sv
module dwhs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  dwhs_pkg::cfg_t      cfg,
    input  logic                step,
    input  logic                start_req,
    input  logic                fault_level,
    output dwhs_pkg::result_t   result
);
    import dwhs_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_FORCE   = 3'd1;
    localparam logic [2:0] PH_READY   = 3'd2;
    localparam logic [2:0] PH_ACK     = 3'd3;
    localparam logic [2:0] PH_ACKWAIT = 3'd4;

    logic [2:0]           phase_reg, phase_next;
    logic [TickWidth-1:0] tick_reg, tick_next;
    logic                 saw_ready_reg, saw_ready_next;
    logic [1:0]           outcome_reg, outcome_next;

    logic [TickWidth-1:0] lim_force, lim_ready, lim_ack, lim_ackwait;
    logic [TickWidth-1:0] wait_base;
    logic [TickWidth:0]   wait_inc;
    logic                 do_ready, do_ackwait;
    logic                 finish;
    logic [1:0]           finish_code;
    logic                 sleep_now, busy_now;

    // A zero limit behaves as one
    always_comb
    begin
        lim_force   = (cfg.sleep_force_ticks == '0) ? TickWidth'(1) : cfg.sleep_force_ticks;
        lim_ready   = (cfg.ready_timeout_ticks == '0) ? TickWidth'(1) : cfg.ready_timeout_ticks;
        lim_ack     = (cfg.ack_pulse_ticks == '0) ? TickWidth'(1) : cfg.ack_pulse_ticks;
        lim_ackwait = (cfg.ack_timeout_ticks == '0) ? TickWidth'(1) : cfg.ack_timeout_ticks;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        saw_ready_next = saw_ready_reg;
        sleep_now      = 1'b1;
        busy_now       = 1'b1;
        do_ready       = 1'b0;
        do_ackwait     = 1'b0;
        wait_base      = tick_reg;
        finish         = 1'b0;
        finish_code    = OUT_NOTRUN;

        case (phase_reg)
            PH_FORCE:
            begin
                if (tick_reg < lim_force)
                begin
                    sleep_now = 1'b0;
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    // release: first high tick is also the first ready sample when the fault pin is present
                    saw_ready_next = 1'b0;
                    tick_next      = '0;
                    if (cfg.fault_pin_present)
                    begin
                        phase_next = PH_READY;
                        do_ready   = 1'b1;
                        wait_base  = '0;
                    end
                    else
                    begin
                        phase_next = PH_ACK;
                    end
                end
            end
            PH_READY:
            begin
                do_ready = 1'b1;
            end
            PH_ACK:
            begin
                if (tick_reg < lim_ack)
                begin
                    sleep_now = 1'b0;
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    tick_next = '0;
                    if (!cfg.fault_pin_present || !saw_ready_reg)
                    begin
                        finish      = 1'b1;
                        finish_code = OUT_UNVER;
                    end
                    else
                    begin
                        phase_next = PH_ACKWAIT;
                        do_ackwait = 1'b1;
                        wait_base  = '0;
                    end
                end
            end
            PH_ACKWAIT:
            begin
                do_ackwait = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                busy_now   = 1'b0;
                if (start_req)
                begin
                    if (!cfg.sleep_pin_present)
                    begin
                        finish      = 1'b1;
                        finish_code = OUT_FAIL;
                    end
                    else
                    begin
                        // start tick is the first low tick of the force time
                        phase_next     = PH_FORCE;
                        saw_ready_next = 1'b0;
                        busy_now       = 1'b1;
                        sleep_now      = 1'b0;
                        tick_next      = TickWidth'(1);
                    end
                end
            end
        endcase

        wait_inc = {1'b0, wait_base} + 1'b1;

        if (do_ready)
        begin
            sleep_now = 1'b1;
            if (!fault_level)
            begin
                saw_ready_next = 1'b1;
                phase_next     = PH_ACK;
                tick_next      = '0;
            end
            else
            begin
                tick_next = wait_inc[TickWidth-1:0];
                if (wait_inc[TickWidth] || wait_inc[TickWidth-1:0] >= lim_ready)
                begin
                    phase_next = PH_ACK;
                    tick_next  = '0;
                end
            end
        end

        if (do_ackwait)
        begin
            sleep_now = 1'b1;
            if (fault_level)
            begin
                finish      = 1'b1;
                finish_code = OUT_OK;
            end
            else
            begin
                tick_next = wait_inc[TickWidth-1:0];
                if (wait_inc[TickWidth] || wait_inc[TickWidth-1:0] >= lim_ackwait)
                begin
                    finish      = 1'b1;
                    finish_code = OUT_FAIL;
                end
            end
        end

        outcome_next = outcome_reg;
        if (finish)
        begin
            outcome_next = finish_code;
            phase_next   = PH_IDLE;
            tick_next    = '0;
            sleep_now    = 1'b1;
            busy_now     = 1'b0;
        end

        result.sleep_level = sleep_now;
        result.busy_res    = busy_now;
        result.done_res    = finish;
        result.outcome     = outcome_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            saw_ready_reg <= 1'b0;
            outcome_reg   <= OUT_NOTRUN;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            saw_ready_reg <= saw_ready_next;
            outcome_reg   <= outcome_next;
        end
    end

endmodule

FILE: design/dwhs_outbuf.sv
module dwhs_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dwhs_pkg::result_t   push_data,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output dwhs_pkg::result_t   out_data
);
    import dwhs_pkg::*;

    logic    head_valid_reg, skid_valid_reg;
    result_t head_reg, skid_reg;
    logic    pop;

    assign pop       = head_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: advance skid into head on pop, else fill the free slot
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                head_reg <= push_data;
            end
        end
    end

endmodule

FILE: design/driver_wake_handshake_sequencer.sv
// A result word is registered in the output buffer before it appears on m_axis.
// One input word is taken per cycle while s_axis_tready is high; the sequencer state advances once per tick word.
// Output holds up to two result words (head plus skid), so s_axis keeps taking a word
// while one result waits; s_axis_tready drops only when both slots are full.
// Reset (rst_n low, asynchronous): sequencer idle, outcome "not run", output buffer
// empty, configuration registers at their documented defaults.
module driver_wake_handshake_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,

    // Tick words in. tdata: [0] start_req, [1] fault_level, [7:2] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,

    // Result words out. tdata: [0] sleep_level, [1] busy_res, [2] done_res,
    // [4:3] outcome, [7:5] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,

    // Configuration writes; accepted every cycle
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwhs_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [dwhs_pkg::CfgDataWidth-1:0]   cfg_data
);
    import dwhs_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    result_t out_result;
    logic    space;
    logic    step;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = space;
    // Advance the sequencer only on a taken tick word
    assign step          = s_axis_tvalid && space;

    dwhs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Phase, tick counter and outcome; next values are the word's result
    dwhs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .start_req   (s_axis_tdata[0]),
        .fault_level (s_axis_tdata[1]),
        .result      (step_result)
    );

    // Hold results until the sink takes them
    dwhs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_result),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {{(8 - ResultWidth){1'b0}}, out_result};

endmodule
